/* rtl/tcgw_pkg.sv */
// ----------------------------------------------------------------------------
// tcgw_pkg
// Shared types, constants and the 5x8 font ROM of the text cursor glyph
// writer.
// ----------------------------------------------------------------------------
package tcgw_pkg;

	// Display geometry
	localparam int SCREEN_WIDTH = 100;
	localparam int SCREEN_PAGES = 8;
	localparam int GLYPH_WIDTH  = 5;
	localparam int CELL_PITCH   = GLYPH_WIDTH + 1;
	localparam int GRID_COLS    = SCREEN_WIDTH / CELL_PITCH;
	localparam int GLYPH_COUNT  = 128;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] COORD_MAX    = 8'h7F;
	localparam logic [2:0] LAST_K       = 3'(GLYPH_WIDTH - 1);

	// Input item kinds
	typedef enum logic {
		ACT_PUT = 1'b0,
		ACT_SET = 1'b1
	} action_t;

	// One glyph draw handed from front to back
	typedef struct packed {
		logic [2:0] row;
		logic [6:0] base_col;
		logic [6:0] code;
	} glyph_cmd_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// Font ROM: column 0 in the top byte, column 4 in the bottom byte
	localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
		40'h3E362A363E, 40'h3E5561553E, 40'h3E6B5F6B3E, 40'h0C1E3C1E0C,
		40'h081C3E1C08, 40'h185E7E5E18, 40'h185C7E5C18, 40'h3E362A363E,
		40'h3E362A363E, 40'h3E362A363E, 40'h3E362A363E, 40'h3E362A363E,
		40'h3E362A363E, 40'h3E362A363E, 40'h3E362A363E, 40'h3E362A363E,
		40'h3E362A363E, 40'h3E362A363E, 40'h3E362A363E, 40'h3E362A363E,
		40'h3E362A363E, 40'h3E362A363E, 40'h3E362A363E, 40'h3E362A363E,
		40'h3E362A363E, 40'h3E362A363E, 40'h3E362A363E, 40'h3E362A363E,
		40'h3E362A363E, 40'h3E362A363E, 40'h3E362A363E, 40'h3E362A363E,
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h143E143E14,
		40'h042A7F2A10, 40'h2616083432, 40'h3649592650, 40'h0000070000,
		40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0101790503,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h4122140800, 40'h0201590502,
		40'h1C2A363E0C, 40'h7E0909097E, 40'h7F4949493E, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4141493A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
		40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
		40'h0000070000, 40'h2054545478, 40'h7F48444438, 40'h3048484820,
		40'h384444487F, 40'h3854545418, 40'h087E090902, 40'h0C5252523E,
		40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
		40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
		40'hFC14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
		40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4038403C,
		40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
		40'h00007F0000, 40'h0041360800, 40'h0007000700, 40'h3E362A363E
	};

	// Byte of glyph column k for a 7-bit code
	function automatic logic [7:0] glyph_col(input logic [6:0] code, input logic [2:0] k);
		logic [39:0] word;
		word = GLYPH_ROM[code];
		case (k)
			3'd0:    glyph_col = word[39:32];
			3'd1:    glyph_col = word[31:24];
			3'd2:    glyph_col = word[23:16];
			3'd3:    glyph_col = word[15:8];
			default: glyph_col = word[7:0];
		endcase
	endfunction

endpackage

/* rtl/tcgw_queue.sv */
// ----------------------------------------------------------------------------
// tcgw_queue
// Two-entry queue of glyph draws between the front and back parts.
// ----------------------------------------------------------------------------
module tcgw_queue
	import tcgw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  glyph_cmd_t push_cmd,
	input  logic       pop,
	output glyph_cmd_t head_cmd,
	output q_status_t  status
);

	glyph_cmd_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign status.empty = (count_q == 2'd0);
	assign status.full  = (count_q == 2'd2);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head_cmd     = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/tcgw_front.sv */
// ----------------------------------------------------------------------------
// tcgw_front
// Accepts input transactions, keeps the character cursor and classifies each
// item; glyph draws are pushed into the queue.
// ----------------------------------------------------------------------------
module tcgw_front
	import tcgw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  logic [7:0]        char_code,
	input  logic signed [7:0] new_col,
	input  logic signed [7:0] new_row,
	input  q_status_t         qs,
	output logic              push,
	output glyph_cmd_t        push_cmd
);

	logic [7:0] cursor_col_q;
	logic [7:0] cursor_row_q;
	logic       accept;
	logic       col_ok;
	logic       row_ok;
	logic       is_put;
	logic       is_newline;
	logic [9:0] base_wide;

	assign in_ready   = !qs.full;
	assign accept     = in_valid && in_ready;
	assign is_put     = (action_t'(action) == ACT_PUT);
	assign is_newline = (char_code == NEWLINE_CODE);

	// Check cursor against the character grid
	assign col_ok = !cursor_col_q[7] && ({24'd0, cursor_col_q} < 32'(GRID_COLS));
	assign row_ok = !cursor_row_q[7] && ({24'd0, cursor_row_q} < 32'(SCREEN_PAGES));

	// Build the draw command
	assign base_wide         = {3'd0, cursor_col_q[6:0]} * 10'(CELL_PITCH);
	assign push_cmd.row      = cursor_row_q[2:0];
	assign push_cmd.base_col = base_wide[6:0];
	assign push_cmd.code     = char_code[6:0];
	assign push = accept && is_put && !is_newline && !char_code[7] && col_ok && row_ok;

	// Update the cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= 8'd0;
			cursor_row_q <= 8'd0;
		end else if (accept) begin
			if (!is_put) begin
				cursor_col_q <= $unsigned(new_col);
				cursor_row_q <= $unsigned(new_row);
			end else if (is_newline) begin
				cursor_col_q <= 8'd0;
				cursor_row_q <= (cursor_row_q == COORD_MAX) ? cursor_row_q : cursor_row_q + 8'd1;
			end else begin
				cursor_col_q <= (cursor_col_q == COORD_MAX) ? cursor_col_q : cursor_col_q + 8'd1;
			end
		end
	end

endmodule

/* rtl/tcgw_back.sv */
// ----------------------------------------------------------------------------
// tcgw_back
// Takes glyph draws from the queue and emits five framebuffer column writes
// per draw through a registered output stage.
// ----------------------------------------------------------------------------
module tcgw_back
	import tcgw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  glyph_cmd_t head_cmd,
	input  q_status_t  qs,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] fb_row,
	output logic [6:0] fb_col,
	output logic [7:0] pixel_byte,
	output logic       last
);

	glyph_cmd_t cmd_q;
	logic [2:0] k_q;
	logic       busy_q;
	logic       out_valid_q;
	logic [2:0] fb_row_q;
	logic [6:0] fb_col_q;
	logic [7:0] pixel_byte_q;
	logic       last_q;
	logic       advance;
	logic       have;
	glyph_cmd_t src_cmd;
	logic [2:0] src_k;

	assign advance = !out_valid_q || out_ready;
	assign have    = busy_q || !qs.empty;
	assign pop     = advance && !busy_q && !qs.empty;

	// Pick the column to emit: current draw, else the queue head
	always_comb begin
		if (busy_q) begin
			src_cmd = cmd_q;
			src_k   = k_q;
		end else begin
			src_cmd = head_cmd;
			src_k   = 3'd0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (advance && have) begin
			fb_row_q     <= src_cmd.row;
			fb_col_q     <= src_cmd.base_col + {4'd0, src_k};
			pixel_byte_q <= glyph_col(src_cmd.code, src_k);
			last_q       <= (src_k == LAST_K);
		end
		if (pop) begin
			cmd_q <= head_cmd;
		end
	end

	// Column counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= 3'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= have;
			if (busy_q) begin
				if (k_q == LAST_K) begin
					busy_q <= 1'b0;
				end
				k_q <= k_q + 3'd1;
			end else if (pop) begin
				busy_q <= 1'b1;
				k_q    <= 3'd1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign fb_row     = fb_row_q;
	assign fb_col     = fb_col_q;
	assign pixel_byte = pixel_byte_q;
	assign last       = last_q;

endmodule

/* rtl/text_cursor_glyph_writer.sv */
// Text cursor glyph writer: a printable character becomes five framebuffer
// column writes on the output side, one per cycle while the output is taken.
// Set-cursor, newline and non-drawing characters are accepted and produce
// nothing. The front keeps the cursor and accepts one transaction per cycle
// while the two-entry draw queue has room; the back emits one column per
// cycle through a registered output while the output is taken, so input
// accepts stall only when two draws are queued behind the one being written.
// ----------------------------------------------------------------------------
// text_cursor_glyph_writer
// Character generator for a page-organised monochrome display: cursor
// handling in front, glyph column writes from the font ROM in back.
// ----------------------------------------------------------------------------
module text_cursor_glyph_writer
	import tcgw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  logic [7:0]        char_code,
	input  logic signed [7:0] new_col,
	input  logic signed [7:0] new_row,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        fb_row,
	output logic [6:0]        fb_col,
	output logic [7:0]        pixel_byte,
	output logic              last
);

	q_status_t  qs;
	logic       push;
	logic       pop;
	glyph_cmd_t push_cmd;
	glyph_cmd_t head_cmd;

	tcgw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.char_code (char_code),
		.new_col   (new_col),
		.new_row   (new_row),
		.qs        (qs),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	tcgw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.status   (qs)
	);

	tcgw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cmd   (head_cmd),
		.qs         (qs),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.fb_row     (fb_row),
		.fb_col     (fb_col),
		.pixel_byte (pixel_byte),
		.last       (last)
	);

endmodule
